/* sv/fih_pkg.sv */
`timescale 1ns / 1ps

package fih_pkg;

   // Default sample width of the stream.
   localparam int SAMPLE_BITS_DEF = 16;

   // Q15 coefficient: gain bits and the arithmetic shift after each product.
   localparam int GAIN_BITS = 15;
   localparam logic [GAIN_BITS-1:0] GAIN_MAX = {GAIN_BITS{1'b1}};

   // Register port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CUTOFF_BITS    = 8;
   localparam int RATE_BITS      = 16;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FILTER_MODE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CUTOFF_HZ      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SAMPLE_RATE_HZ = 2'd2;

   localparam logic                   RST_FILTER_MODE    = 1'b0;
   localparam logic [CUTOFF_BITS-1:0] RST_CUTOFF_HZ      = 8'd1;
   localparam logic [RATE_BITS-1:0]   RST_SAMPLE_RATE_HZ = 16'd100;

   // Divider step counter.
   localparam int DIV_CNT_BITS = $clog2(GAIN_BITS + 1);

   typedef enum logic [1:0] {
      GAIN_IDLE,
      GAIN_LOAD,
      GAIN_DIV
   } gain_state_type;

   // Coefficient and mode handed from the gain unit to the datapath.
   typedef struct packed {
      logic                 busy;
      logic                 lowpass;
      logic [GAIN_BITS-1:0] gain;
   } gain_cfg_type;

endpackage

/* sv/fih_if.sv */
`timescale 1ns / 1ps

interface fih_req_if #(
   parameter int SampleBits = fih_pkg::SAMPLE_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [SampleBits-1:0] sample_in;
   logic                         restart;

   modport source (output valid, output sample_in, output restart, input ready);
   modport sink (input valid, input sample_in, input restart, output ready);
endinterface

interface fih_rsp_if #(
   parameter int SampleBits = fih_pkg::SAMPLE_BITS_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic signed [SampleBits-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

/* sv/fih_gain.sv */
`timescale 1ns / 1ps

module fih_gain (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [fih_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fih_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output fih_pkg::gain_cfg_type               gain_cfg
);
   import fih_pkg::*;

   logic                   mode_ff, mode_in;
   logic [CUTOFF_BITS-1:0] cutoff_ff, cutoff_in;
   logic [RATE_BITS-1:0]   rate_ff, rate_in;
   logic                   cfg_write;

   gain_state_type state_ff, state_in;
   logic [RATE_BITS-1:0]    rem_ff, rem_in;
   logic [RATE_BITS-1:0]    den_ff, den_in;
   logic [GAIN_BITS-1:0]    quo_ff, quo_in;
   logic [GAIN_BITS-1:0]    gain_ff, gain_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;

   logic [RATE_BITS-1:0] cut_eff;
   logic [RATE_BITS-1:0] den_calc;
   logic [RATE_BITS-1:0] num_calc;
   logic [RATE_BITS:0]   rem_dbl;
   logic                 rem_ge;

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      mode_in   = mode_ff;
      cutoff_in = cutoff_ff;
      rate_in   = rate_ff;
      cfg_write = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            REG_FILTER_MODE: begin
               mode_in   = csr_wdata[0];
               cfg_write = 1'b1;
            end
            REG_CUTOFF_HZ: begin
               cutoff_in = csr_wdata[CUTOFF_BITS-1:0];
               cfg_write = 1'b1;
            end
            REG_SAMPLE_RATE_HZ: begin
               rate_in   = csr_wdata[RATE_BITS-1:0];
               cfg_write = 1'b1;
            end
            default: begin
               cfg_write = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= RST_FILTER_MODE;
         cutoff_ff <= RST_CUTOFF_HZ;
         rate_ff   <= RST_SAMPLE_RATE_HZ;
      end else begin
         mode_ff   <= mode_in;
         cutoff_ff <= cutoff_in;
         rate_ff   <= rate_in;
      end
   end

   // Cutoff of zero counts as one; the denominator wraps at 16 bits.
   assign cut_eff  = (cutoff_ff == '0) ? RATE_BITS'(1) : RATE_BITS'(cutoff_ff);
   assign den_calc = rate_ff + cut_eff;
   assign num_calc = mode_ff ? cut_eff : rate_ff;

   // Restoring division, one quotient bit per cycle.
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_ge  = (rem_dbl >= {1'b0, den_ff});

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      gain_in  = gain_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         GAIN_IDLE: begin
            if (cfg_write) begin
               state_in = GAIN_LOAD;
            end
         end
         GAIN_LOAD: begin
            den_in = den_calc;
            rem_in = num_calc;
            quo_in = '0;
            cnt_in = DIV_CNT_BITS'(GAIN_BITS);
            if (den_calc == '0) begin
               gain_in  = '0;
               state_in = GAIN_IDLE;
            end else if (num_calc >= den_calc) begin
               gain_in  = GAIN_MAX;
               state_in = GAIN_IDLE;
            end else begin
               state_in = GAIN_DIV;
            end
         end
         GAIN_DIV: begin
            rem_in = rem_ge ? RATE_BITS'(rem_dbl - {1'b0, den_ff}) : rem_dbl[RATE_BITS-1:0];
            quo_in = {quo_ff[GAIN_BITS-2:0], rem_ge};
            cnt_in = cnt_ff - DIV_CNT_BITS'(1);
            if (cnt_ff == DIV_CNT_BITS'(1)) begin
               gain_in  = {quo_ff[GAIN_BITS-2:0], rem_ge};
               state_in = GAIN_IDLE;
            end
         end
         default: begin
            state_in = GAIN_IDLE;
         end
      endcase
      if (cfg_write) begin
         state_in = GAIN_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= GAIN_LOAD;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      gain_ff <= gain_in;
   end

   assign gain_cfg.busy    = (state_ff != GAIN_IDLE);
   assign gain_cfg.lowpass = mode_ff;
   assign gain_cfg.gain    = gain_ff;

endmodule

/* sv/fih_core.sv */
`timescale 1ns / 1ps

module fih_core #(
   parameter int SampleBits = fih_pkg::SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fih_pkg::gain_cfg_type        gain_cfg,
   input  logic                         load,
   input  logic signed [SampleBits-1:0] sample_in,
   input  logic                         restart,
   input  logic                         fire,
   output logic signed [SampleBits-1:0] sample_out
);
   import fih_pkg::*;

   localparam int DW = SampleBits + 2;
   localparam int PW = DW + GAIN_BITS + 1;
   localparam int SW = SampleBits + 4;

   localparam logic signed [SW-1:0] SAT_HI = {{5{1'b0}}, {(SampleBits-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = {{5{1'b1}}, {(SampleBits-1){1'b0}}};

   logic signed [SampleBits-1:0] x_ff;
   logic                         restart_ff;
   logic signed [SampleBits-1:0] li_ff, li_in;
   logic signed [SampleBits-1:0] lo_ff, lo_in;
   logic                         primed_ff;
   logic signed [SampleBits-1:0] y_ff;

   logic                         prime;
   logic signed [SampleBits-1:0] lo_eff;
   logic signed [SampleBits-1:0] li_eff;
   logic signed [DW-1:0]         diff;
   logic signed [GAIN_BITS:0]    gain_s;
   logic signed [PW-1:0]         prod;
   logic signed [DW:0]           shifted;
   logic signed [SW-1:0]         sum;
   logic signed [SampleBits-1:0] y_calc;

   // A restart or an unprimed filter loads the history from this sample.
   assign prime  = !primed_ff || restart_ff;
   assign lo_eff = prime ? (gain_cfg.lowpass ? x_ff : '0) : lo_ff;
   assign li_eff = (prime && !gain_cfg.lowpass) ? x_ff : li_ff;

   always_comb begin
      if (gain_cfg.lowpass) begin
         diff = DW'(x_ff) - DW'(lo_eff);
      end else begin
         diff = DW'(lo_eff) + DW'(x_ff) - DW'(li_eff);
      end
   end

   assign gain_s  = $signed({1'b0, gain_cfg.gain});
   assign prod    = PW'(diff) * PW'(gain_s);
   assign shifted = prod[PW-1:GAIN_BITS];

   always_comb begin
      if (gain_cfg.lowpass) begin
         sum = SW'(shifted) + SW'(lo_eff);
      end else begin
         sum = SW'(shifted);
      end
      if (sum > SAT_HI) begin
         y_calc = SAT_HI[SampleBits-1:0];
      end else if (sum < SAT_LO) begin
         y_calc = SAT_LO[SampleBits-1:0];
      end else begin
         y_calc = sum[SampleBits-1:0];
      end
   end

   assign li_in = x_ff;
   assign lo_in = y_calc;

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff       <= sample_in;
         restart_ff <= restart;
      end
      if (fire) begin
         y_ff <= y_calc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         li_ff     <= '0;
         lo_ff     <= '0;
         primed_ff <= 1'b0;
      end else if (fire) begin
         li_ff     <= li_in;
         lo_ff     <= lo_in;
         primed_ff <= 1'b1;
      end
   end

   assign sample_out = y_ff;

endmodule

/* sv/first_order_iir_hpf_lpf.sv */
// One-pole IIR filter for a stream of signed samples, high-pass or low-pass as the mode
// register selects, with a Q15 gain derived from the cutoff and sample rate registers.
// Each sample beat passes through an input register, one multiply with arithmetic
// shift and saturation, and a result register, so a new sample is taken every cycle
// while the output side does not stall and no coefficient is being derived. The
// filter history is updated as each result is registered, so it feeds back from one
// sample to the next. The gain is derived by a bit-serial divider: after reset and
// after every write to one of the three registers the input is held off (a load step
// and up to 15 quotient steps) while the coefficient is computed.
// The first sample after reset, and any beat with restart set, primes the history.
`timescale 1ns / 1ps

module first_order_iir_hpf_lpf #(
   parameter int SampleBits = fih_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [fih_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fih_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   fih_req_if.sink                            req,
   fih_rsp_if.source                          rsp
);
   import fih_pkg::*;

   gain_cfg_type gain_cfg;

   // Valid flags of the input stage and the result stage.
   logic in_valid_ff, in_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance;
   logic fire;
   logic accept;

   fih_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .gain_cfg  (gain_cfg)
   );

   // The result stage can take a new value when it is empty or being drained.
   assign advance = !out_valid_ff || rsp.ready;
   assign fire    = in_valid_ff && advance;

   // The input stage frees up when its sample moves on, so one sample can wait in it
   // while the previous result waits in the result stage.
   assign req.ready = !gain_cfg.busy && (!in_valid_ff || advance);
   assign accept    = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   fih_core #(
      .SampleBits (SampleBits)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .gain_cfg   (gain_cfg),
      .load       (accept),
      .sample_in  (req.sample_in),
      .restart    (req.restart),
      .fire       (fire),
      .sample_out (rsp.sample_out)
   );

   assign rsp.valid = out_valid_ff;

endmodule

/* verif/first_order_iir_hpf_lpf_tb.sv */
`timescale 1ns / 1ps

// Self-checking testbench for the one-pole high-pass / low-pass filter.
// Every sample beat that the block accepts is run through a filter model kept in this
// module, and the predicted output sample is queued. Each result beat is checked
// against the oldest queued prediction. The configuration is changed only while the
// block has no work in flight, so the model's gain always matches the block's.
module first_order_iir_hpf_lpf_tb;
   import fih_pkg::*;

   localparam int SAMPLE_W = SAMPLE_BITS_DEF;
   localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

   // Index 3 decodes to no register; a write there must leave the settings alone.
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE = 2'd3;

   localparam int RANDOM_SAMPLES = 600;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int BACKPRESSURE_HOLD = 80;

   logic                      clock;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   fih_req_if #(.SampleBits(SAMPLE_W)) req_ch ();
   fih_rsp_if #(.SampleBits(SAMPLE_W)) rsp_ch ();

   first_order_iir_hpf_lpf #(.SampleBits(SAMPLE_W)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch),
      .rsp       (rsp_ch)
   );

   // Mirror of the register settings, updated as each write is issued.
   logic                   cfg_lowpass;
   logic [CUTOFF_BITS-1:0] cfg_cutoff;
   logic [RATE_BITS-1:0]   cfg_rate;

   // Mirror of the filter history.
   longint hist_in;
   longint hist_out;
   bit     hist_primed;

   logic signed [SAMPLE_W-1:0] expected_samples[$];
   int error_count = 0;
   int stall_cycles = 0;

   // Sender burst control: with gaps enabled, the sender drops valid for a random gap
   // whenever its current burst runs out.
   bit sender_gappy = 1'b0;
   int burst_left = 0;

   // Set by a test to make the receiver refuse results; the value sets the hold length.
   int rsp_hold_request = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Coefficient as the block should derive it from the current settings. A cutoff of
   // zero counts as one and the denominator wraps like a 16-bit adder.
   function automatic logic [GAIN_BITS-1:0] q15_gain();
      int unsigned c;
      int unsigned den;
      int unsigned num;
      c = (cfg_cutoff == '0) ? 1 : 32'(cfg_cutoff);
      den = (32'(cfg_rate) + c) & 32'hFFFF;
      num = cfg_lowpass ? c : 32'(cfg_rate);
      if (den == 0)
         return '0;
      if (num >= den)
         return GAIN_MAX;
      return GAIN_BITS'((num * 32768) / den);
   endfunction

   // Advances the filter history by one sample and returns the filtered output.
   function automatic logic signed [SAMPLE_W-1:0] filter_sample(
      input logic signed [SAMPLE_W-1:0] x,
      input logic                       restart_bit
   );
      longint xv;
      longint g;
      longint y;
      xv = longint'(x);
      g = longint'(q15_gain());
      if (restart_bit)
         hist_primed = 1'b0;
      // An unprimed history is loaded from this sample: high-pass starts from a zero
      // output, low-pass starts with the output equal to the sample.
      if (!hist_primed) begin
         if (cfg_lowpass) begin
            hist_out = xv;
         end else begin
            hist_in = xv;
            hist_out = 0;
         end
         hist_primed = 1'b1;
      end
      if (cfg_lowpass)
         y = hist_out + ((g * (xv - hist_out)) >>> 15);
      else
         y = (g * (hist_out + xv - hist_in)) >>> 15;
      if (y > SAMPLE_HI)
         y = SAMPLE_HI;
      else if (y < SAMPLE_LO)
         y = SAMPLE_LO;
      hist_in = xv;
      hist_out = y;
      return y[SAMPLE_W-1:0];
   endfunction

   // Offers one sample beat and waits for it to be taken. Valid stays high after the
   // beat so that back-to-back beats never toggle it within one time step.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic restart_bit);
      int gap;
      if (sender_gappy && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0)
         burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= x;
      req_ch.restart   <= restart_bit;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      expected_samples.push_back(filter_sample(x, restart_bit));
   endtask

   // Stops offering beats and waits until every predicted result has been checked,
   // plus a short settle time so the block is truly idle before a register write.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (index)
         REG_FILTER_MODE:    cfg_lowpass = data[0];
         REG_CUTOFF_HZ:      cfg_cutoff = data[CUTOFF_BITS-1:0];
         REG_SAMPLE_RATE_HZ: cfg_rate = data[RATE_BITS-1:0];
         default: ;
      endcase
   endtask

   // Writes all three registers once the block is idle. The unused upper bits of the
   // write data are random so that every data bit toggles over the run.
   task automatic apply_settings(input logic lowpass, input logic [CUTOFF_BITS-1:0] cutoff,
                                 input logic [RATE_BITS-1:0] rate);
      logic [CSR_DATA_BITS-1:0] data;
      drain_results();
      data = CSR_DATA_BITS'($urandom);
      data[0] = lowpass;
      csr_write(REG_FILTER_MODE, data);
      data = CSR_DATA_BITS'($urandom);
      data[CUTOFF_BITS-1:0] = cutoff;
      csr_write(REG_CUTOFF_HZ, data);
      csr_write(REG_SAMPLE_RATE_HZ, rate);
   endtask

   // Reset settings: high-pass with a gain just under one. The first beat primes the
   // history, then full-scale swings drive the output into saturation.
   task automatic test_reset_defaults();
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd1, 1'b1);
   endtask

   // Low-pass at full gain with a zero sample rate. The mode change keeps the history
   // from the high-pass run, and a restart in the middle primes it again.
   task automatic test_lowpass_extremes();
      apply_settings(1'b1, 8'd255, 16'd0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh0000, 1'b0);
   endtask

   // Gain corners: a denominator that wraps to zero, one that wraps to a small value,
   // a zero cutoff standing for one, and a zero numerator. A write to the unused index
   // in between must change nothing.
   task automatic test_gain_corners();
      apply_settings(1'b0, 8'd1, 16'hFFFF);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b0);
      apply_settings(1'b1, 8'd0, 16'hFFFF);
      send_sample(16'sh1234, 1'b0);
      send_sample(16'sh8000, 1'b0);
      apply_settings(1'b0, 8'd255, 16'hFFFF);
      csr_write(REG_SPARE, 16'hFFFF);
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7FFF, 1'b0);
      apply_settings(1'b1, 8'd0, 16'd200);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      apply_settings(1'b0, 8'd0, 16'd0);
      send_sample(16'sh4000, 1'b0);
      send_sample(16'shC000, 1'b0);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering beats,
   // so the block's pipeline fills and it must stall its input.
   task automatic test_backpressure();
      apply_settings(1'b0, 8'd10, 16'd1000);
      sender_gappy = 1'b0;
      rsp_hold_request = BACKPRESSURE_HOLD;
      for (int i = 0; i < 24; i++)
         send_sample(SAMPLE_W'($urandom), 1'b0);
   endtask

   function automatic logic [CUTOFF_BITS-1:0] random_cutoff();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return 8'd1;
         2: return 8'd255;
         default: return CUTOFF_BITS'($urandom);
      endcase
   endfunction

   // Rates near the top of the range can make the denominator wrap.
   function automatic logic [RATE_BITS-1:0] random_rate();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 16'hFFFF;
         2: return 16'hFFFF - RATE_BITS'($urandom_range(0, 255));
         3: return RATE_BITS'($urandom_range(1, 300));
         default: return RATE_BITS'($urandom);
      endcase
   endfunction

   // Streams of random length under random settings. Samples mix full-range noise, a
   // slowly drifting level with small noise, full-scale values and held values, and an
   // occasional restart primes the history again.
   task automatic test_random_streams();
      int sent;
      int stream_len;
      int level;
      int pick;
      logic signed [SAMPLE_W-1:0] s;
      sent = 0;
      level = 0;
      s = '0;
      while (sent < RANDOM_SAMPLES) begin
         apply_settings(1'($urandom_range(0, 1)), random_cutoff(), random_rate());
         if ($urandom_range(0, 7) == 0)
            csr_write(REG_SPARE, CSR_DATA_BITS'($urandom));
         sender_gappy = ($urandom_range(0, 2) != 0);
         burst_left = 0;
         stream_len = $urandom_range(10, 60);
         level = $urandom_range(0, 65535) - 32768;
         for (int i = 0; i < stream_len; i++) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0, 1, 2, 3: s = SAMPLE_W'($urandom);
               4, 5, 6: begin
                  level = level + $urandom_range(0, 511) - 256;
                  s = SAMPLE_W'(level + $urandom_range(0, 63) - 32);
               end
               7: s = SAMPLE_HI[SAMPLE_W-1:0];
               8: s = SAMPLE_LO[SAMPLE_W-1:0];
               default: ;
            endcase
            send_sample(s, $urandom_range(0, 15) == 0);
         end
         sent += stream_len;
      end
   endtask

   // Receiver: ready follows a rotating 8-bit pattern that a tick counter redraws at
   // intervals. An all-ones pattern gives stretches without stalls. A hold request from
   // a test parks ready low for the requested hold length.
   initial begin
      int hold;
      int tick;
      logic [7:0] pattern;
      rsp_ch.ready <= 1'b0;
      pattern = 8'hFF;
      tick = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            hold = rsp_hold_request;
            rsp_hold_request = 0;
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         tick++;
         if (tick % 64 == 0) begin
            if ($urandom_range(0, 2) == 0) begin
               pattern = 8'hFF;
            end else begin
               pattern = 8'($urandom);
               pattern[3] = 1'b1;
            end
         end
         rsp_ch.ready <= pattern[0];
         pattern = {pattern[0], pattern[7:1]};
      end
   end

   // Result checker: each result beat is compared with the oldest prediction.
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got sample_out %0d",
                     $time, rsp_ch.sample_out);
            error_count++;
         end else begin
            if (rsp_ch.sample_out !== expected_samples[0]) begin
               $display("%0t: sample_out mismatch, expected %0d, got %0d",
                        $time, expected_samples[0], rsp_ch.sample_out);
               error_count++;
            end
            void'(expected_samples.pop_front());
         end
      end
   end

   // Watchdog: ends the run when no beat moves on either side for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= REG_FILTER_MODE;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.sample_in <= '0;
      req_ch.restart   <= 1'b0;
      cfg_lowpass = RST_FILTER_MODE;
      cfg_cutoff = RST_CUTOFF_HZ;
      cfg_rate = RST_SAMPLE_RATE_HZ;
      hist_in = 0;
      hist_out = 0;
      hist_primed = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_lowpass_extremes();
      test_gain_corners();
      test_backpressure();
      test_random_streams();

      // Let the last results drain, then keep watching the result side in case the block
      // emits anything it should not.
      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_samples.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
